FILE: design/pkf_pkg.sv
// ----------------------------------------------------------------------------
// pkf_pkg: shared types, constants and functions for packet_length_fft
// transform size, word widths, sequencer states and the twiddle table
// ----------------------------------------------------------------------------
package pkf_pkg;

  localparam int POINTS = 64;
  localparam int LOG    = $clog2(POINTS);
  localparam int HALF   = POINTS / 2;
  localparam int IW     = LOG;
  localparam int SW     = (LOG > 1) ? $clog2(LOG) : 1;
  localparam int CW     = 7;
  localparam int WW     = 40;
  localparam int BW     = 41;
  localparam int OW     = 33;
  localparam int PW     = 56;
  localparam int AW     = 57;

  localparam logic [CW-1:0] COUNT_MAX = 7'd127;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_CLIPPED = 2'd1;
  localparam logic [1:0] STATUS_TOO_FEW = 2'd2;

  localparam logic OP_SAMPLE    = 1'b0;
  localparam logic OP_TERMINATE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BRD,
    ST_BMUL,
    ST_BRND,
    ST_BWJ,
    ST_BWK,
    ST_ORD,
    ST_OLD,
    ST_OUT
  } state_t;

  // multiplier operand pairs and accumulator actions
  typedef enum logic [1:0] {
    MS_WR_XR,
    MS_WI_XI,
    MS_WR_XI,
    MS_WI_XR
  } mul_sel_t;

  typedef struct packed {
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_en;
    mul_sel_t acc_sel;
    logic     rnd_en;
  } mac_ctl_t;

  // round(32768*cos(2*pi*k/64)) for k = 0..16, +1.0 saturated
  function automatic logic signed [15:0] qcos(input logic [4:0] k);
    logic signed [15:0] v;
    unique case (k)
      5'd0:  v = 16'sd32767;
      5'd1:  v = 16'sd32610;
      5'd2:  v = 16'sd32138;
      5'd3:  v = 16'sd31357;
      5'd4:  v = 16'sd30274;
      5'd5:  v = 16'sd28899;
      5'd6:  v = 16'sd27246;
      5'd7:  v = 16'sd25330;
      5'd8:  v = 16'sd23170;
      5'd9:  v = 16'sd20788;
      5'd10: v = 16'sd18205;
      5'd11: v = 16'sd15447;
      5'd12: v = 16'sd12540;
      5'd13: v = 16'sd9512;
      5'd14: v = 16'sd6393;
      5'd15: v = 16'sd3212;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // the quarter point itself goes through the second arm, which yields zero
  function automatic logic signed [15:0] cos64(input logic [5:0] k);
    logic signed [15:0] v;
    if (k < 6'd16) begin
      v = qcos(k[4:0]);
    end else if (k <= 6'd32) begin
      v = -qcos(5'(6'd32 - k));
    end else if (k <= 6'd48) begin
      v = -qcos(5'(k - 6'd32));
    end else begin
      v = qcos(5'(7'd64 - {1'b0, k}));
    end
    return v;
  endfunction

  function automatic logic [IW-1:0] rev_bits(input logic [IW-1:0] x);
    logic [IW-1:0] r;
    for (int b = 0; b < IW; b++) begin
      r[b] = x[IW-1-b];
    end
    return r;
  endfunction

endpackage

FILE: design/pkf_ram.sv
// ----------------------------------------------------------------------------
// pkf_ram: generic memory, one write port and two registered read ports
// read data holds while the read enable is low
// ----------------------------------------------------------------------------
module pkf_ram #(
  parameter int WIDTH = 40,
  parameter int ADDR  = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ADDR-1:0]  waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [ADDR-1:0]  raddr_a,
  input  logic [ADDR-1:0]  raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [2**ADDR];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: design/pkf_mac.sv
// ----------------------------------------------------------------------------
// pkf_mac: shared complex multiply unit
// one 16x40 product per cycle while mul_en is set, accumulated into real and
// imaginary sums, then rounded to the butterfly's lower input
// ----------------------------------------------------------------------------
module pkf_mac (
  input  logic                          clk,
  input  pkf_pkg::mac_ctl_t             ctl,
  input  logic signed [15:0]            wr,
  input  logic signed [15:0]            wi,
  input  logic signed [pkf_pkg::WW-1:0] xr,
  input  logic signed [pkf_pkg::WW-1:0] xi,
  output logic signed [pkf_pkg::BW-1:0] b1r,
  output logic signed [pkf_pkg::BW-1:0] b1i
);
  import pkf_pkg::*;

  logic signed [15:0]   mul_a;
  logic signed [WW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] acc_i;
  logic signed [AW-1:0] rnd_r;
  logic signed [AW-1:0] rnd_i;

  always_comb begin
    case (ctl.mul_sel)
      MS_WR_XR: begin mul_a = wr; mul_b = xr; end
      MS_WI_XI: begin mul_a = wi; mul_b = xi; end
      MS_WR_XI: begin mul_a = wr; mul_b = xi; end
      default:  begin mul_a = wi; mul_b = xr; end
    endcase
  end

  // operands sign-extended to the full product width
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= PW'(mul_a) * PW'(mul_b);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      case (ctl.acc_sel)
        MS_WR_XR: acc_r <= AW'(prod);
        MS_WI_XI: acc_r <= acc_r - AW'(prod);
        MS_WR_XI: acc_i <= AW'(prod);
        default:  acc_i <= acc_i + AW'(prod);
      endcase
    end
  end

  // round half up, then arithmetic shift by 15
  assign rnd_r = (acc_r + AW'(16384)) >>> 15;
  assign rnd_i = (acc_i + AW'(16384)) >>> 15;

  always_ff @(posedge clk) begin
    if (ctl.rnd_en) begin
      b1r <= rnd_r[BW-1:0];
      b1i <= rnd_i[BW-1:0];
    end
  end

endmodule

FILE: design/packet_length_fft.sv
// ----------------------------------------------------------------------------
// packet_length_fft: normalized radix-2 FFT over a flow's packet lengths
// stores the first POINTS lengths; emits POINTS bins, or one too-few beat, on flow end
// ----------------------------------------------------------------------------
// Packet-length beats (op 0) are taken one per cycle while the block is idle
// and written straight into the working store at their bit-reversed place, so
// no separate load pass is needed. A terminate beat (op 1) with fewer than
// POINTS packets gives one result beat with the too-few status. Otherwise the
// block runs log2(POINTS) stages of POINTS/2 butterflies each, every butterfly
// going through the one shared 16x40 multiplier four times. A butterfly is a
// read, the four multiplies and their accumulation, a round and two write-backs
// (the working store has a single write port). The bins then leave one beat at
// a time: each is read from the store, loaded into the output register and held
// there until the sink takes it with out_ready. in_ready is high only while the
// block is idle. Each bin is saturated to 33 bits; status is clipped when more
// than POINTS packets came, and last marks the final beat.
module packet_length_fft (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [15:0] pkt_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  bin_index,
  output logic signed [32:0] bin_real,
  output logic signed [32:0] bin_imag,
  output logic [1:0]  status,
  output logic        last
);
  import pkf_pkg::*;

  state_t state;
  state_t state_next;

  logic [CW-1:0] packet_count;
  logic [SW-1:0] stage;
  logic [IW-1:0] bfly;
  logic [2:0]    mstep;
  logic [IW-1:0] bin;
  logic [1:0]    run_status;

  logic in_fire;
  logic out_fire;
  logic count_short;

  // butterfly addressing
  logic [IW-1:0] low_mask;
  logic [IW-1:0] top_j;
  logic [IW-1:0] top_k;
  logic [IW-1:0] tw_low;
  logic [5:0]    tw;
  logic signed [15:0] wr;
  logic signed [15:0] wi;

  // working store ports
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata_r;
  logic [WW-1:0] ram_wdata_i;
  logic          ram_re;
  logic [IW-1:0] ram_raddr_a;
  logic signed [WW-1:0] rd_jr;
  logic signed [WW-1:0] rd_ji;
  logic signed [WW-1:0] rd_kr;
  logic signed [WW-1:0] rd_ki;

  mac_ctl_t mac_ctl;
  logic signed [BW-1:0] b1r;
  logic signed [BW-1:0] b1i;
  logic signed [BW:0]   sum_r;
  logic signed [BW:0]   sum_i;
  logic signed [BW:0]   dif_r;
  logic signed [BW:0]   dif_i;
  logic signed [OW-1:0] sat_r;
  logic signed [OW-1:0] sat_i;

  logic last_bfly;
  logic last_stage;
  logic last_bin;

  assign in_fire     = in_valid && in_ready;
  assign out_fire    = out_valid && out_ready;
  assign count_short = packet_count < CW'(POINTS);
  assign last_bfly   = bfly == IW'(HALF - 1);
  assign last_stage  = stage == SW'(LOG - 1);
  assign last_bin    = bin == IW'(POINTS - 1);

  // j has a zero inserted at bit position stage, k has a one there
  always_comb begin
    low_mask = IW'((1 << stage) - 1);
    top_j    = ((bfly & ~low_mask) << 1) | (bfly & low_mask);
    top_k    = top_j | IW'(1 << stage);
    tw_low   = IW'((top_j & low_mask) << (LOG - 1 - int'(stage))) & IW'(HALF - 1);
    tw       = 6'(tw_low) << (6 - LOG);
    wr       = cos64(tw);
    wi       = -cos64(tw - 6'd16);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && op == OP_TERMINATE) begin
          state_next = count_short ? ST_OUT : ST_BRD;
        end
      end
      ST_BRD:  state_next = ST_BMUL;
      ST_BMUL: if (mstep == 3'd4) state_next = ST_BRND;
      ST_BRND: state_next = ST_BWJ;
      ST_BWJ:  state_next = ST_BWK;
      ST_BWK: begin
        if (last_bfly && last_stage) begin
          state_next = ST_ORD;
        end else begin
          state_next = ST_BRD;
        end
      end
      ST_ORD:  state_next = ST_OLD;
      ST_OLD:  state_next = ST_OUT;
      ST_OUT: begin
        if (out_ready) begin
          state_next = last ? ST_IDLE : ST_ORD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = top_j;
    ram_wdata_r   = sum_r[WW:1];
    ram_wdata_i   = sum_i[WW:1];
    ram_raddr_a   = top_j;
    mac_ctl       = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        ram_we      = in_fire && op == OP_SAMPLE && count_short;
        ram_waddr   = rev_bits(packet_count[IW-1:0]);
        ram_wdata_r = WW'({pkt_len, 16'h0000});
        ram_wdata_i = '0;
      end
      ST_BRD: ram_re = 1'b1;
      ST_BMUL: begin
        mac_ctl.mul_en  = mstep < 3'd4;
        mac_ctl.mul_sel = mul_sel_t'(mstep[1:0]);
        mac_ctl.acc_en  = mstep != 3'd0;
        mac_ctl.acc_sel = mul_sel_t'(2'(mstep - 3'd1));
      end
      ST_BRND: mac_ctl.rnd_en = 1'b1;
      ST_BWJ:  ram_we = 1'b1;
      ST_BWK: begin
        ram_we      = 1'b1;
        ram_waddr   = top_k;
        ram_wdata_r = dif_r[WW:1];
        ram_wdata_i = dif_i[WW:1];
      end
      ST_ORD: begin
        ram_re      = 1'b1;
        ram_raddr_a = bin;
      end
      ST_OLD: ;
      ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // flow packet count, saturating; cleared when the flow ends
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_count <= '0;
    end else if (in_fire) begin
      if (op == OP_TERMINATE) begin
        packet_count <= '0;
      end else if (packet_count != COUNT_MAX) begin
        packet_count <= packet_count + 1'b1;
      end
    end
  end

  // stage, butterfly, multiply step and bin counters
  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      bfly  <= '0;
      mstep <= '0;
      bin   <= '0;
    end else begin
      if (state == ST_IDLE) begin
        stage <= '0;
        bfly  <= '0;
        bin   <= '0;
      end
      if (state == ST_BMUL) begin
        mstep <= (mstep == 3'd4) ? 3'd0 : mstep + 3'd1;
      end
      if (state == ST_BWK) begin
        if (last_bfly) begin
          bfly  <= '0;
          stage <= last_stage ? stage : stage + 1'b1;
        end else begin
          bfly <= bfly + 1'b1;
        end
      end
      if (state == ST_OUT && out_ready && !last) begin
        bin <= bin + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && op == OP_TERMINATE) begin
      run_status <= (packet_count > CW'(POINTS)) ? STATUS_CLIPPED : STATUS_DONE;
    end
  end

  pkf_ram #(.WIDTH(WW), .ADDR(IW)) u_ram_real (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata_r),
    .re      (ram_re),
    .raddr_a (ram_raddr_a),
    .raddr_b (top_k),
    .rdata_a (rd_jr),
    .rdata_b (rd_kr)
  );

  pkf_ram #(.WIDTH(WW), .ADDR(IW)) u_ram_imag (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata_i),
    .re      (ram_re),
    .raddr_a (ram_raddr_a),
    .raddr_b (top_k),
    .rdata_a (rd_ji),
    .rdata_b (rd_ki)
  );

  pkf_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .wr  (wr),
    .wi  (wi),
    .xr  (rd_kr),
    .xi  (rd_ki),
    .b1r (b1r),
    .b1i (b1i)
  );

  // butterfly halves; the shift by one is the per-stage normalization
  assign sum_r = (BW+1)'(rd_jr) + (BW+1)'(b1r);
  assign sum_i = (BW+1)'(rd_ji) + (BW+1)'(b1i);
  assign dif_r = (BW+1)'(rd_jr) - (BW+1)'(b1r);
  assign dif_i = (BW+1)'(rd_ji) - (BW+1)'(b1i);

  // clamp a stored bin to the 33-bit output range
  always_comb begin
    if (rd_jr > WW'(signed'(34'sh0FFFFFFFF))) begin
      sat_r = {1'b0, {(OW-1){1'b1}}};
    end else if (rd_jr < WW'(signed'(34'sh300000000))) begin
      sat_r = {1'b1, {(OW-1){1'b0}}};
    end else begin
      sat_r = rd_jr[OW-1:0];
    end
    if (rd_ji > WW'(signed'(34'sh0FFFFFFFF))) begin
      sat_i = {1'b0, {(OW-1){1'b1}}};
    end else if (rd_ji < WW'(signed'(34'sh300000000))) begin
      sat_i = {1'b1, {(OW-1){1'b0}}};
    end else begin
      sat_i = rd_ji[OW-1:0];
    end
  end

  // result register, loaded for the too-few beat or for each bin
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_fire && op == OP_TERMINATE && count_short) begin
      bin_index <= '0;
      bin_real  <= '0;
      bin_imag  <= '0;
      status    <= STATUS_TOO_FEW;
    end else if (state == ST_OLD) begin
      bin_index <= 6'(bin);
      bin_real  <= sat_r;
      bin_imag  <= sat_i;
      status    <= run_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last <= 1'b0;
    end else if (state == ST_IDLE && in_fire && op == OP_TERMINATE) begin
      last <= count_short;
    end else if (state == ST_OLD) begin
      last <= last_bin;
    end
  end

endmodule

FILE: sim/packet_length_fft_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packet_length_fft_tb: self-checking bench for the packet length FFT
// feeds flows of packet lengths, predicts every bin and compares each beat
// ----------------------------------------------------------------------------
module packet_length_fft_tb;
  import pkf_pkg::*;

  localparam int WATCHDOG = 20000;

  typedef struct {
    logic [5:0]         idx;
    logic signed [32:0] re;
    logic signed [32:0] im;
    logic [1:0]         st;
    logic               lst;
  } bin_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = OP_SAMPLE;
  logic [15:0] pkt_len = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] bin_index;
  logic signed [32:0] bin_real;
  logic signed [32:0] bin_imag;
  logic [1:0] status;
  logic last;

  // predictor state: stored lengths and packet count of the open flow
  logic [15:0] flow_lens [POINTS];
  int          flow_count;
  bin_t        bins_due [$];
  int          error_count = 0;
  int          idle_cycles = 0;
  bit          hold_sink;
  int          burst_left;

  packet_length_fft uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .pkt_len(pkt_len),
    .out_valid(out_valid), .out_ready(out_ready),
    .bin_index(bin_index), .bin_real(bin_real), .bin_imag(bin_imag),
    .status(status), .last(last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // twiddle on the 64-point circle, Q1.15 with +1.0 saturated
  function automatic longint circle_cos(int k);
    int q;
    longint tab [17] = '{32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
                         23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
    q = k & 63;
    if (q <= 16) return tab[q];
    if (q <= 32) return -tab[32 - q];
    if (q <= 48) return -tab[q - 32];
    return tab[64 - q];
  endfunction

  function automatic logic signed [32:0] clamp33(longint v);
    if (v > 64'sd4294967295) return 33'sh0FFFFFFFF;
    if (v < -64'sd4294967296) return 33'sh100000000;
    return v[32:0];
  endfunction

  // normalized fft of the stored flow, queued as expected bins
  task automatic predict_spectrum(logic [1:0] st);
    longint wre [POINTS];
    longint wim [POINTS];
    longint wr, wi, xr, xi, pr, pi, ar, ai;
    int nb, n, a, k, tw, r;
    bin_t b;
    nb = $clog2(POINTS);
    for (int i = 0; i < POINTS; i++) begin
      r = 0;
      for (int q = 0; q < nb; q++) begin
        if (i & (1 << q)) r |= 1 << (nb - 1 - q);
      end
      wre[i] = longint'(flow_lens[r]) * 65536;
      wim[i] = 0;
    end
    n = 1;
    a = POINTS / 2;
    for (int s = 0; s < nb; s++) begin
      for (int j = 0; j < POINTS; j++) begin
        if (!(j & n)) begin
          k = j + n;
          tw = ((j * a) & (POINTS / 2 - 1)) * (64 / POINTS);
          wr = circle_cos(tw);
          wi = -circle_cos(tw - 16);
          xr = wre[k];
          xi = wim[k];
          pr = (wr * xr - wi * xi + 16384) >>> 15;
          pi = (wr * xi + wi * xr + 16384) >>> 15;
          ar = wre[j];
          ai = wim[j];
          wre[j] = (ar + pr) >>> 1;
          wim[j] = (ai + pi) >>> 1;
          wre[k] = (ar - pr) >>> 1;
          wim[k] = (ai - pi) >>> 1;
        end
      end
      n <<= 1;
      a >>= 1;
    end
    for (int i = 0; i < POINTS; i++) begin
      b.idx = i[5:0];
      b.re = clamp33(wre[i]);
      b.im = clamp33(wim[i]);
      b.st = st;
      b.lst = (i == POINTS - 1);
      bins_due.push_back(b);
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    error_count++;
  endtask

  // one beat into the block; bursts with random gaps between them
  task automatic send_beat(logic o, logic [15:0] len);
    bin_t b;
    int gap;
    if (burst_left == 0) begin
      gap = int'($urandom_range(0, 4));
      burst_left = int'($urandom_range(1, 20));
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    op <= o;
    pkt_len <= len;
    do @(posedge clk); while (!in_ready);
    if (o == OP_SAMPLE) begin
      if (flow_count < POINTS) flow_lens[flow_count] = len;
      if (flow_count < COUNT_MAX) flow_count++;
    end else begin
      if (flow_count < POINTS) begin
        b = '{6'd0, 33'sd0, 33'sd0, STATUS_TOO_FEW, 1'b1};
        bins_due.push_back(b);
      end else begin
        predict_spectrum(flow_count > POINTS ? STATUS_CLIPPED : STATUS_DONE);
      end
      flow_count = 0;
    end
  endtask

  // drop valid once the sender has nothing more to offer for now
  task automatic pause_input;
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  task automatic send_flow(int npk, int mode);
    logic [15:0] v;
    for (int i = 0; i < npk; i++) begin
      case (mode)
        0: v = 16'($urandom);
        1: v = 16'hFFFF;
        2: v = 16'h0000;
        3: v = 16'($urandom_range(40, 1500));
        default: v = (i % 2) ? 16'hFFFF : 16'h0000;
      endcase
      send_beat(OP_SAMPLE, v);
    end
    send_beat(OP_TERMINATE, 16'($urandom));
  endtask

  task automatic test_too_few;
    send_beat(OP_TERMINATE, 16'hFFFF);
    send_flow(POINTS - 1, 0);
  endtask

  task automatic test_extremes;
    send_flow(POINTS, 4);
  endtask

  // count saturation: well past 127 packets
  task automatic test_count_saturation;
    send_flow(140, 3);
  endtask

  // sink holds off for a fixed stretch while the sender keeps offering beats
  task automatic test_backpressure;
    fork
      begin
        hold_sink = 1'b1;
        repeat (3000) @(posedge clk);
        hold_sink = 1'b0;
      end
      begin
        send_flow(POINTS, 0);
        send_flow(0, 0);
        pause_input;
      end
    join
  endtask

  task automatic test_random;
    send_flow(int'($urandom_range(0, 4)), 0);
  endtask

  // sink stall pattern, plus the long hold-off
  always @(posedge clk) begin
    if (rst || hold_sink) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 7) != 0) || ($urandom_range(0, 3) == 0);
    end
  end

  // checker: compare each accepted bin against the oldest expected one
  always @(posedge clk) begin
    bin_t w;
    if (!rst && out_valid && out_ready) begin
      if (bins_due.size() == 0) begin
        report_mismatch("unexpected beat", bin_index, -1);
      end else begin
        w = bins_due.pop_front();
        if (bin_index !== w.idx) report_mismatch("bin_index", bin_index, w.idx);
        if (bin_real !== w.re) report_mismatch("bin_real", bin_real, w.re);
        if (bin_imag !== w.im) report_mismatch("bin_imag", bin_imag, w.im);
        if (status !== w.st) report_mismatch("status", status, w.st);
        if (last !== w.lst) report_mismatch("last", last, w.lst);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    flow_count = 0;
    hold_sink = 1'b0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_too_few;
    test_extremes;
    test_count_saturation;
    test_backpressure;
    test_random;
    pause_input;
    while (bins_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/pkf_pkg.sv
design/pkf_ram.sv
design/pkf_mac.sv
design/packet_length_fft.sv
sim/packet_length_fft_tb.sv
